[hdl/assert_macros.svh]
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/pnfce_pkg.sv]
`default_nettype none

package pnfce_pkg;

	localparam int AW = 19;
	localparam int DW = 8;

	localparam int MEM_BYTES_DEF    = 524288;
	localparam int SECTOR_BYTES_DEF = 4096;

	// smallest store size; sets the coarse reduction table for address folding
	localparam int COARSE_SHIFT = 13;

	localparam logic [AW-1:0] UNLOCK_A = 19'h05555;
	localparam logic [AW-1:0] UNLOCK_B = 19'h02AAA;

	localparam logic [DW-1:0] CMD_UNLOCK1   = 8'hAA;
	localparam logic [DW-1:0] CMD_UNLOCK2   = 8'h55;
	localparam logic [DW-1:0] CMD_PROGRAM   = 8'hA0;
	localparam logic [DW-1:0] CMD_ERASE     = 8'h80;
	localparam logic [DW-1:0] CMD_SEC_ERASE = 8'h30;
	localparam logic [DW-1:0] CMD_CHIP_ERASE = 8'h10;

	localparam logic [DW-1:0] ERASED_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

endpackage

`default_nettype wire

[hdl/parallel_nor_flash_command_engine_top.sv]
// Byte-wide NOR flash model with an unlock-sequence command decoder. An item
// is taken when start is high and busy is low; its result appears on
// read_data/busy_res with done high for exactly one cycle, registered after
// the execute state, and the receiver cannot stall it. Busy drops in the cycle
// that done is shown, so a plain read, write or tick is finished before the
// next item is taken: the array read is registered, then the execute state
// modifies and writes back. A sector erase delivers its result the same way,
// then keeps busy high through the sector-base computation (reciprocal
// multiply, base product, one-step correction) and a sweep over every byte of
// the sector, as the single write port of the array fills it with 0xFF. A chip
// erase keeps busy high while the sweep covers all MEM_BYTES bytes. After
// reset the array is cleared the same way: busy stays high until that sweep
// ends, before the first item is taken. Configuration writes are taken at any time.
`default_nettype none

`include "assert_macros.svh"

module parallel_nor_flash_command_engine_top
	import pnfce_pkg::*;
#(
	parameter int MEM_BYTES    = MEM_BYTES_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    op,
	input  logic [AW-1:0] address,
	input  logic [DW-1:0] write_data,
	output logic          done,
	output logic [DW-1:0] read_data,
	output logic          busy_res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	localparam int MAW    = $clog2(MEM_BYTES);
	localparam int EW     = AW + 1;
	localparam int NCOARSE = 2 ** (AW - COARSE_SHIFT);
	localparam logic [AW-1:0] SEC_RECIP = AW'((2 ** AW) / SECTOR_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_BASE,
		ST_FIX,
		ST_SWEEP
	} state_t;

	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_UNL1,
		CMD_UNL2,
		CMD_PROG,
		CMD_ESETUP,
		CMD_EUNL1,
		CMD_EREADY
	} cmd_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic          busy_flag_q;
	logic [DW-1:0] lpb_q;
	logic          real_timing_q;
	logic          done_q;
	logic [DW-1:0] read_data_q;
	logic          busy_res_q;
	logic [MAW:0]  sweep_q;
	logic [MAW:0]  sweep_end_q;
	logic [AW-1:0] quot_q;
	logic [AW-1:0] sbase_q;

	logic [1:0]    op_s1;
	logic [AW-1:0] addr_s1;
	logic [DW-1:0] data_s1;
	logic [AW-1:0] cell_s1;

	logic [DW-1:0] flash_q [MEM_BYTES];
	logic [DW-1:0] rdata_q;

	logic          accept;

	// address folding: coarse subtract from a table, then one correction
	logic [AW-1:0] coarse_base [NCOARSE];
	logic [AW-1:0] fold0;
	logic [AW-1:0] cell_in;

	for (genvar k = 0; k < NCOARSE; k++) begin : g_coarse
		assign coarse_base[k] =
			AW'((k * (2 ** COARSE_SHIFT) / MEM_BYTES) * MEM_BYTES);
	end

	always_comb begin
		fold0 = address - coarse_base[address[AW-1:COARSE_SHIFT]];
		if ({1'b0, fold0} >= EW'(MEM_BYTES))
			cell_in = AW'({1'b0, fold0} - EW'(MEM_BYTES));
		else
			cell_in = fold0;
	end

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign read_data = read_data_q;
	assign busy_res  = busy_res_q;
	assign cfg_ready = 1'b1;

	// execute stage
	logic          at_a;
	logic          at_b;
	cmd_t          cmd_next;
	logic          busy_next;
	logic [DW-1:0] lpb_next;
	logic          prog_we;
	logic          do_sector;
	logic          do_chip;
	logic [DW-1:0] rd_val;

	always_comb begin
		at_a      = (addr_s1 == UNLOCK_A);
		at_b      = (addr_s1 == UNLOCK_B);
		cmd_next  = cmd_q;
		busy_next = busy_flag_q;
		lpb_next  = lpb_q;
		prog_we   = 1'b0;
		do_sector = 1'b0;
		do_chip   = 1'b0;
		rd_val    = '0;
		case (op_s1)
			OP_WRITE: begin
				cmd_next = CMD_IDLE;
				case (cmd_q)
					CMD_IDLE: begin
						if (at_a && data_s1 == CMD_UNLOCK1) cmd_next = CMD_UNL1;
					end
					CMD_UNL1: begin
						if (at_b && data_s1 == CMD_UNLOCK2) cmd_next = CMD_UNL2;
					end
					CMD_UNL2: begin
						if (at_a && data_s1 == CMD_PROGRAM)
							cmd_next = CMD_PROG;
						else if (at_a && data_s1 == CMD_ERASE)
							cmd_next = CMD_ESETUP;
					end
					CMD_PROG: begin
						prog_we   = 1'b1;
						lpb_next  = data_s1;
						busy_next = real_timing_q;
					end
					CMD_ESETUP: begin
						if (at_a && data_s1 == CMD_UNLOCK1) cmd_next = CMD_EUNL1;
					end
					CMD_EUNL1: begin
						if (at_b && data_s1 == CMD_UNLOCK2) cmd_next = CMD_EREADY;
					end
					CMD_EREADY: begin
						if (data_s1 == CMD_SEC_ERASE) begin
							do_sector = 1'b1;
							lpb_next  = ERASED_BYTE;
							busy_next = real_timing_q;
						end else if (at_a && data_s1 == CMD_CHIP_ERASE) begin
							do_chip   = 1'b1;
							lpb_next  = ERASED_BYTE;
							busy_next = real_timing_q;
						end
					end
					default: cmd_next = CMD_IDLE;
				endcase
			end
			OP_READ: begin
				rd_val = rdata_q;
				if (busy_flag_q)
					rd_val = {~lpb_q[DW-1], rdata_q[DW-2:0]};
			end
			OP_TICK: busy_next = 1'b0;
			default: ;
		endcase
	end

	// sector base: reciprocal estimate of the sector index, then one correction
	logic [EW-1:0] fix_e0;
	logic [EW-1:0] fix_e1;
	logic          fix_fit;
	logic [EW-1:0] end0;
	logic [EW-1:0] end1;
	logic [AW-1:0] sec_base;
	logic [EW-1:0] sec_end;
	logic [MAW:0]  sweep_next;

	always_comb begin
		fix_e0     = {1'b0, sbase_q} + EW'(SECTOR_BYTES);
		fix_e1     = {1'b0, sbase_q} + EW'(2 * SECTOR_BYTES);
		fix_fit    = ({1'b0, cell_s1} >= fix_e0);
		end0       = (fix_e0 > EW'(MEM_BYTES)) ? EW'(MEM_BYTES) : fix_e0;
		end1       = (fix_e1 > EW'(MEM_BYTES)) ? EW'(MEM_BYTES) : fix_e1;
		sec_base   = fix_fit ? fix_e0[AW-1:0] : sbase_q;
		sec_end    = fix_fit ? end1 : end0;
		sweep_next = sweep_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			cmd_q         <= CMD_IDLE;
			busy_flag_q   <= 1'b0;
			lpb_q         <= '0;
			real_timing_q <= 1'b0;
			done_q        <= 1'b0;
			read_data_q   <= '0;
			busy_res_q    <= 1'b0;
			sweep_q       <= '0;
			sweep_end_q   <= (MAW+1)'(MEM_BYTES);
			quot_q        <= '0;
			sbase_q       <= '0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			if (cfg_valid && cfg_ready)
				real_timing_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					cmd_q       <= cmd_next;
					busy_flag_q <= busy_next;
					lpb_q       <= lpb_next;
					read_data_q <= rd_val;
					busy_res_q  <= busy_next;
					if (do_sector) begin
						state_q <= ST_DIV;
					end else if (do_chip) begin
						state_q     <= ST_SWEEP;
						sweep_q     <= '0;
						sweep_end_q <= (MAW+1)'(MEM_BYTES);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					quot_q  <= AW'(((2*AW)'(cell_s1) * (2*AW)'(SEC_RECIP)) >> AW);
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					sbase_q <= quot_q * AW'(SECTOR_BYTES);
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					sweep_q     <= (MAW+1)'(sec_base);
					sweep_end_q <= (MAW+1)'(sec_end);
					state_q     <= ST_SWEEP;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_next;
					if (sweep_next == sweep_end_q) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			addr_s1 <= address;
			data_s1 <= write_data;
			cell_s1 <= cell_in;
		end
	end

	// array: one write port, one registered read port; one item at a time,
	// so the write-back lands before the next item's read
	logic           mem_we;
	logic [MAW-1:0] mem_wa;
	logic [DW-1:0]  mem_wd;

	always_comb begin
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
			mem_wa = sweep_q[MAW-1:0];
			mem_wd = ERASED_BYTE;
		end else begin
			mem_we = (state_q == ST_EXEC) && prog_we;
			mem_wa = cell_s1[MAW-1:0];
			mem_wd = rdata_q & data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) flash_q[mem_wa] <= mem_wd;
		rdata_q <= flash_q[cell_in[MAW-1:0]];
	end

	`ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC)
	`ASSERT_IMPLY(a_done_after_exec, clk, arst_n, done_q, $past(state_q) == ST_EXEC)
	`ASSERT_IMPLY(a_sweep_bound, clk, arst_n, state_q == ST_SWEEP, sweep_q < sweep_end_q)
	`ASSERT_IMPLY(a_nonread_zero, clk, arst_n, done_q && op_s1 != OP_READ, read_data_q == '0)
	`ASSERT_ALWAYS(a_fold_range, clk, arst_n, ({1'b0, cell_in} < EW'(MEM_BYTES)))

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pnfce_pkg::*;

	localparam int FLASH_BYTES = MEM_BYTES_DEF;
	localparam int SECTOR_SIZE = SECTOR_BYTES_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned RANDOM_PHASE_ITEMS = 356;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_UNLOCKED1,
		CS_UNLOCKED2,
		CS_PROGRAM,
		CS_ERASE_SETUP,
		CS_ERASE_UNLOCKED1,
		CS_ERASE_READY
	} command_state_t;

	typedef struct packed {
		logic [DW-1:0] read_data;
		logic          busy_res;
	} flash_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [1:0]    op = OP_WRITE;
	logic [AW-1:0] address = '0;
	logic [DW-1:0] write_data = '0;
	logic          done;
	logic [DW-1:0] read_data;
	logic          busy_res;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_data = 1'b0;

	// predictor state
	logic [DW-1:0]  flash_image [FLASH_BYTES];
	command_state_t cmd_state;
	logic           poll_busy;
	logic [DW-1:0]  last_prog_byte;
	logic           timing_on;

	flash_result_t pending_results [$];
	flash_result_t want;
	int unsigned   error_count = 0;
	int unsigned   items_sent = 0;
	int unsigned   cycle_count = 0;
	int unsigned   sector_erase_budget = 28;
	bit            chip_erase_allowed = 1'b0;
	bit            no_gaps = 1'b0;
	logic [AW-1:0] hot_cells [12];

	parallel_nor_flash_command_engine_top #(
		.MEM_BYTES(FLASH_BYTES),
		.SECTOR_BYTES(SECTOR_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.address(address),
		.write_data(write_data),
		.done(done),
		.read_data(read_data),
		.busy_res(busy_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL parallel_nor_flash_command_engine_top");
		$finish;
	end

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_data %02h busy_res %0b", read_data, busy_res);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data: expected %02h, got %02h", want.read_data, read_data);
					error_count++;
				end
				if (busy_res !== want.busy_res) begin
					$error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
					error_count++;
				end
			end
		end
	end

	function automatic void reset_flash_image();
		int unsigned i;
		for (i = 0; i < FLASH_BYTES; i++) flash_image[i] = ERASED_BYTE;
		cmd_state = CS_IDLE;
		poll_busy = 1'b0;
		last_prog_byte = '0;
		timing_on = 1'b0;
	endfunction

	function automatic void apply_bus_write(logic [AW-1:0] a, logic [DW-1:0] d);
		logic           at_a;
		logic           at_b;
		command_state_t nxt;
		int unsigned    cell_idx;
		int unsigned    base;
		int unsigned    lim;
		int unsigned    i;
		at_a = (a == UNLOCK_A);
		at_b = (a == UNLOCK_B);
		nxt = CS_IDLE;
		cell_idx = a % FLASH_BYTES;
		case (cmd_state)
			CS_IDLE: if (at_a && d == CMD_UNLOCK1) nxt = CS_UNLOCKED1;
			CS_UNLOCKED1: if (at_b && d == CMD_UNLOCK2) nxt = CS_UNLOCKED2;
			CS_UNLOCKED2: begin
				if (at_a && d == CMD_PROGRAM) nxt = CS_PROGRAM;
				else if (at_a && d == CMD_ERASE) nxt = CS_ERASE_SETUP;
			end
			CS_PROGRAM: begin
				flash_image[cell_idx] = flash_image[cell_idx] & d;
				last_prog_byte = d;
				poll_busy = timing_on;
			end
			CS_ERASE_SETUP: if (at_a && d == CMD_UNLOCK1) nxt = CS_ERASE_UNLOCKED1;
			CS_ERASE_UNLOCKED1: if (at_b && d == CMD_UNLOCK2) nxt = CS_ERASE_READY;
			CS_ERASE_READY: begin
				if (d == CMD_SEC_ERASE) begin
					base = cell_idx - cell_idx % SECTOR_SIZE;
					lim = base + SECTOR_SIZE;
					if (lim > FLASH_BYTES) lim = FLASH_BYTES;
					for (i = base; i < lim; i++) flash_image[i] = ERASED_BYTE;
					last_prog_byte = ERASED_BYTE;
					poll_busy = timing_on;
				end else if (at_a && d == CMD_CHIP_ERASE) begin
					for (i = 0; i < FLASH_BYTES; i++) flash_image[i] = ERASED_BYTE;
					last_prog_byte = ERASED_BYTE;
					poll_busy = timing_on;
				end
			end
			default: ;
		endcase
		cmd_state = nxt;
	endfunction

	function automatic flash_result_t predict_flash_result(logic [1:0] kind,
			logic [AW-1:0] a, logic [DW-1:0] d);
		flash_result_t r;
		r.read_data = '0;
		case (kind)
			OP_WRITE: apply_bus_write(a, d);
			OP_READ: begin
				r.read_data = flash_image[a % FLASH_BYTES];
				if (poll_busy) r.read_data[7] = ~last_prog_byte[7];
			end
			OP_TICK: poll_busy = 1'b0;
			default: ;
		endcase
		r.busy_res = poll_busy;
		return r;
	endfunction

	function automatic int unsigned sender_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [AW-1:0] step_address(int unsigned k);
		return (k == 1 || k == 4) ? UNLOCK_B : UNLOCK_A;
	endfunction

	function automatic logic [DW-1:0] step_byte(int unsigned k, bit to_program);
		case (k)
			0, 3: return CMD_UNLOCK1;
			1, 4: return CMD_UNLOCK2;
			2: return to_program ? CMD_PROGRAM : CMD_ERASE;
			default: return CMD_SEC_ERASE;
		endcase
	endfunction

	function automatic logic [AW-1:0] hot_cell();
		return hot_cells[$urandom_range(0, 11)];
	endfunction

	task automatic issue_item(input logic [1:0] kind, input logic [AW-1:0] a,
			input logic [DW-1:0] d);
		int unsigned gap;
		start <= 1'b1;
		op <= kind;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_flash_result(kind, a, d));
		items_sent++;
		gap = sender_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// keeps erases within the cycle budget
	task automatic issue_write(input logic [AW-1:0] a, input logic [DW-1:0] d);
		logic [DW-1:0] data;
		data = d;
		if (cmd_state == CS_ERASE_READY) begin
			if (data == CMD_SEC_ERASE) begin
				if (sector_erase_budget == 0) data ^= 8'h01;
				else sector_erase_budget--;
			end else if (a == UNLOCK_A && data == CMD_CHIP_ERASE && !chip_erase_allowed) begin
				data ^= 8'h01;
			end
		end
		issue_item(OP_WRITE, a, data);
	endtask

	task automatic unlock_prefix(input int unsigned n, input bit to_program);
		int unsigned k;
		for (k = 0; k < n; k++) issue_write(step_address(k), step_byte(k, to_program));
	endtask

	task automatic program_sequence(input logic [AW-1:0] a, input logic [DW-1:0] d);
		unlock_prefix(3, 1'b1);
		issue_write(a, d);
	endtask

	task automatic erase_sequence(input logic [AW-1:0] a, input logic [DW-1:0] d);
		unlock_prefix(5, 1'b0);
		issue_write(a, d);
	endtask

	task automatic broken_sequence();
		bit            to_program;
		int unsigned   cut;
		logic [AW-1:0] a;
		logic [DW-1:0] d;
		to_program = 1'($urandom_range(0, 1));
		cut = $urandom_range(0, to_program ? 2 : 5);
		unlock_prefix(cut, to_program);
		a = step_address(cut);
		d = step_byte(cut, to_program);
		if (cut == 5 || $urandom_range(0, 1)) begin
			d = DW'($urandom);
			if (d == step_byte(cut, to_program)) d ^= 8'h01;
		end else begin
			a = AW'($urandom);
			if (a == step_address(cut)) a ^= 19'h1;
		end
		issue_write(a, d);
	endtask

	task automatic noise_item();
		logic [AW-1:0] a;
		logic [DW-1:0] d;
		a = AW'($urandom);
		d = DW'($urandom);
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 3))
					0: a = UNLOCK_A;
					1: a = UNLOCK_B;
					2: a = UNLOCK_A ^ (19'h1 << $urandom_range(15, 18));
					default: ;
				endcase
				if ($urandom_range(0, 1))
					d = step_byte($urandom_range(0, 5), 1'($urandom_range(0, 1)));
				issue_write(a, d);
			end
			1: issue_item(OP_UNUSED, a, d);
			2: issue_item(OP_READ, a, d);
			3: issue_item(OP_TICK, a, d);
			default: issue_write(a, d);
		endcase
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_timing(input logic value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		timing_on = value;
	endtask

	task automatic pick_hot_cells();
		logic [6:0]  mid_sector;
		logic [6:0]  sec;
		logic [11:0] low;
		int unsigned i;
		mid_sector = 7'($urandom);
		for (i = 0; i < 12; i++) begin
			sec = (i < 4) ? 7'h00 : ((i < 8) ? mid_sector : 7'h7F);
			low = 12'($urandom);
			hot_cells[i] = {sec, low};
		end
		hot_cells[0] = '0;
		hot_cells[11] = '1;
	endtask

	task automatic run_basic_access();
		issue_item(OP_READ, 19'h7FFFF, 8'h00);
		issue_item(OP_UNUSED, 19'h7FFFF, 8'hFF);
		issue_item(OP_TICK, 19'h00000, 8'h00);
		program_sequence(19'h7FFFF, 8'h00);
		issue_item(OP_READ, 19'h7FFFF, 8'hFF);
	endtask

	task automatic run_data_polling();
		drain_results();
		write_timing(1'b1);
		program_sequence(19'h00000, 8'h7F);
		issue_item(OP_READ, 19'h00000, 8'h00);
		issue_item(OP_TICK, 19'h7FFFF, 8'hFF);
		issue_item(OP_READ, 19'h00000, 8'h00);
	endtask

	task automatic run_chip_erase();
		issue_write(UNLOCK_A, CMD_UNLOCK1);
		issue_write(UNLOCK_B, CMD_UNLOCK2 ^ 8'h01);
		chip_erase_allowed = 1'b1;
		erase_sequence(UNLOCK_A, CMD_CHIP_ERASE);
		chip_erase_allowed = 1'b0;
		issue_item(OP_READ, 19'h00000, 8'h00);
		issue_item(OP_TICK, 19'h00000, 8'h00);
		issue_item(OP_READ, 19'h7FFFF, 8'h00);
	endtask

	task automatic run_random_traffic(input logic timing, input bit steady);
		int unsigned   first;
		int unsigned   pick;
		logic [AW-1:0] a;
		logic [11:0]   low;
		drain_results();
		write_timing(timing);
		pick_hot_cells();
		no_gaps = steady;
		first = items_sent;
		while (items_sent - first < RANDOM_PHASE_ITEMS) begin
			pick = $urandom_range(0, 99);
			a = hot_cell();
			if (pick < 32) begin
				program_sequence(a, DW'($urandom));
			end else if (pick < 38) begin
				low = 12'($urandom);
				if (sector_erase_budget != 0) erase_sequence({a[18:12], low}, CMD_SEC_ERASE);
				else program_sequence(a, DW'($urandom));
			end else if (pick < 48) begin
				broken_sequence();
			end else if (pick < 73) begin
				if ($urandom_range(0, 3) == 0) a = AW'($urandom);
				issue_item(OP_READ, a, DW'($urandom));
			end else if (pick < 83) begin
				issue_item(OP_TICK, AW'($urandom), DW'($urandom));
			end else begin
				noise_item();
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		reset_flash_image();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		run_basic_access();
		run_data_polling();
		run_chip_erase();
		run_random_traffic(1'b0, 1'b0);
		run_random_traffic(1'b1, 1'b0);
		run_random_traffic(1'b1, 1'b1);
		run_random_traffic(1'b0, 1'b0);
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS parallel_nor_flash_command_engine_top");
		end else begin
			$display("FAIL parallel_nor_flash_command_engine_top");
		end
		$finish;
	end

endmodule
